// ----- src/adaptive_interval_histogram_assert.svh -----
// assertion macros used by the interval histogram top level
`ifndef ADAPTIVE_INTERVAL_HISTOGRAM_ASSERT_SVH
`define ADAPTIVE_INTERVAL_HISTOGRAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AIH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval histogram assertion failed");

// next-cycle implication, checked outside reset
`define AIH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval histogram assertion failed");

`endif

// ----- src/aih_pkg.sv -----
// shared types, constants and functions of the interval histogram
package aih_pkg;

   localparam int CmdW      = 2;
   localparam int HistoW    = 3;
   localparam int BinIdxW   = 5;
   localparam int TimeW     = 48;
   localparam int CountW    = 32;
   localparam int MbuW      = 5;
   localparam int BinWidthW = 24;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 24;

   // tick counter width; values above the field width are cut to the field
   localparam int TimeBits = 48;
   localparam logic [TimeW-1:0] TimeMask =
      (TimeBits >= TimeW) ? {TimeW{1'b1}} : TimeW'((64'd1 << TimeBits) - 64'd1);

   localparam int DefNumHistograms = 8;
   localparam int DefMaxBins       = 16;

   localparam logic [CmdW-1:0] CmdStart = 2'd0;
   localparam logic [CmdW-1:0] CmdStop  = 2'd1;
   localparam logic [CmdW-1:0] CmdRead  = 2'd2;
   localparam logic [CmdW-1:0] CmdClear = 2'd3;

   localparam logic [CsrIdxW-1:0] CsrMaxBinsUsed = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrBinWidth    = 2'd1;

   localparam logic [MbuW-1:0]      MbuReset      = 5'd16;
   localparam logic [BinWidthW-1:0] BinWidthReset = 24'd1000;

   typedef struct packed {
      logic [MbuW-1:0]      max_bins_used;
      logic [BinWidthW-1:0] bin_width;
   } cfg_type;

   typedef struct packed {
      logic [CountW-1:0] count;
      logic [TimeW-1:0]  lo;
      logic [TimeW-1:0]  hi;
   } stats_type;

   localparam stats_type StatsReset = '{count: '0, lo: '1, hi: '0};

   // word that walks down the chain of bin cells
   typedef struct packed {
      logic                 valid;
      logic                 skip;
      logic [CmdW-1:0]      cmd;
      logic [BinIdxW-1:0]   bin_index;
      logic [TimeW-1:0]     elapsed;
      logic                 counted;
      logic                 opened;
      logic                 prev_open;
      logic [BinIdxW-1:0]   first;
      logic [TimeW-1:0]     center;
      stats_type            stats;
      logic                 in_use;
   } token_type;

   typedef struct packed {
      logic [TimeW-1:0]   elapsed;
      logic [BinIdxW-1:0] hit_bin;
      logic               opened_bin;
      logic [TimeW-1:0]   bin_center;
      stats_type          stats;
      logic               bin_in_use;
   } rsp_type;

   function automatic stats_type tally(stats_type s, logic [TimeW-1:0] e);
      stats_type r;
      r = s;
      if (s.count != {CountW{1'b1}}) r.count = s.count + CountW'(1);
      if (e < s.lo) r.lo = e;
      if (e > s.hi) r.hi = e;
      return r;
   endfunction

endpackage

// ----- src/adaptive_interval_histogram.sv -----
// top level of the adaptive interval histogram block
// Usage:
//  A command word (start, stop, read, clear) with its histogram index, bin
//  index and tick timestamp is taken at a clock edge where start is high and
//  busy is low. Busy stays high until the command's result word is out.
//  The command walks a row of MAX_BINS bin cells, one cell per cycle, and
//  ends in the overflow bin; every cell tests, counts, opens, clears or
//  reports its own bin as the word passes.
//  The result word shows on the rsp_ ports for one cycle with rsp_valid,
//  registered as the word leaves the overflow stage; the receiver cannot
//  hold it. Busy drops with the result, so no new command is taken until
//  the last result is out; the length of the cell row sets the spacing.
//  Configuration is written through csr_write_enable, csr_index and
//  csr_wdata while busy is low; register 0 is the open-bin limit, register 1
//  the bin width in ticks.
//  A synchronous reset clears all start times, bins and open counts at once,
//  restores the register defaults and drops busy.
`include "adaptive_interval_histogram_assert.svh"

module adaptive_interval_histogram import aih_pkg::*; #(
   parameter int NUM_HISTOGRAMS = DefNumHistograms,
   parameter int MAX_BINS = DefMaxBins
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CmdW-1:0]      req_cmd,
   input  logic [HistoW-1:0]    req_histo_index,
   input  logic [BinIdxW-1:0]   req_bin_index,
   input  logic [TimeW-1:0]     req_timestamp,
   input  logic                 csr_write_enable,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   output logic                 rsp_valid,
   output logic [TimeW-1:0]     rsp_elapsed,
   output logic [BinIdxW-1:0]   rsp_hit_bin,
   output logic                 rsp_opened_bin,
   output logic [BinIdxW-1:0]   rsp_filled_bins,
   output logic [TimeW-1:0]     rsp_bin_center,
   output logic [CountW-1:0]    rsp_bin_count,
   output logic [TimeW-1:0]     rsp_bin_min,
   output logic [TimeW-1:0]     rsp_bin_max,
   output logic                 rsp_bin_in_use
);

   localparam int HistoAddrW = (NUM_HISTOGRAMS > 1) ? $clog2(NUM_HISTOGRAMS) : 1;
   localparam int OpenW      = $clog2(MAX_BINS + 1);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StLoad = 2'd1;
   localparam logic [1:0] StRun  = 2'd2;

   cfg_type                cfg_ff;
   logic [1:0]             state_ff;
   logic [1:0]             state_in;
   logic [CmdW-1:0]        cmd_ff;
   logic [HistoW-1:0]      histo_ff;
   logic                   histo_ok_ff;
   logic [BinIdxW-1:0]     bin_ff;
   logic [TimeW-1:0]       ts_ff;
   logic [TimeW-1:0]       start_ff [NUM_HISTOGRAMS];
   logic [OpenW-1:0]       open_ff  [NUM_HISTOGRAMS];
   logic [BinIdxW-1:0]     filled_ff;
   token_type              tok0_ff;
   token_type              tok_launch;
   token_type              tok [MAX_BINS+1];
   rsp_type                rsp;

   logic                   accept;
   logic                   histo_in_range;
   logic [HistoAddrW-1:0]  req_addr;
   logic [HistoAddrW-1:0]  haddr;
   logic                   chain_done;
   logic [OpenW-1:0]       open_next;

   assign accept         = start && (state_ff == StIdle);
   assign busy           = (state_ff != StIdle);
   assign histo_in_range = int'(req_histo_index) < NUM_HISTOGRAMS;
   assign req_addr       = HistoAddrW'(req_histo_index);
   assign haddr          = HistoAddrW'(histo_ff);
   assign chain_done     = tok[MAX_BINS].valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle:  if (accept) state_in = StLoad;
         StLoad:  state_in = StRun;
         StRun:   if (chain_done) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      tok_launch           = '0;
      tok_launch.valid     = 1'b1;
      tok_launch.skip      = !histo_ok_ff;
      tok_launch.cmd       = cmd_ff;
      tok_launch.bin_index = bin_ff;
      tok_launch.elapsed   = (ts_ff - start_ff[haddr]) & TimeMask;
      tok_launch.prev_open = 1'b1;
      tok_launch.stats     = StatsReset;
   end

   always_comb begin
      priority if (tok[MAX_BINS].cmd == CmdClear) begin
         open_next = '0;
      end else if (tok[MAX_BINS].opened) begin
         open_next = open_ff[haddr] + OpenW'(1);
      end else begin
         open_next = open_ff[haddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_bins_used <= MbuReset;
         cfg_ff.bin_width     <= BinWidthReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrMaxBinsUsed: cfg_ff.max_bins_used <= csr_wdata[MbuW-1:0];
            CsrBinWidth:    cfg_ff.bin_width     <= csr_wdata[BinWidthW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         for (int h = 0; h < NUM_HISTOGRAMS; h++) begin
            start_ff[h] <= '0;
            open_ff[h]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (accept && histo_in_range && (req_cmd == CmdStart)) begin
            start_ff[req_addr] <= req_timestamp & TimeMask;
         end
         if (chain_done && !tok[MAX_BINS].skip) begin
            open_ff[haddr] <= open_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
      end else if (state_ff == StLoad) begin
         tok0_ff <= tok_launch;
      end else begin
         tok0_ff.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_cmd;
         histo_ff    <= req_histo_index;
         histo_ok_ff <= histo_in_range;
         bin_ff      <= req_bin_index;
         ts_ff       <= req_timestamp & TimeMask;
      end
      if (chain_done) begin
         filled_ff <= tok[MAX_BINS].skip ? '0 : BinIdxW'(open_next);
      end
   end

   assign tok[0] = tok0_ff;

   for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
      aih_cell #(
         .CELL_INDEX     (i),
         .NUM_HISTOGRAMS (NUM_HISTOGRAMS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cfg        (cfg_ff),
         .histo_addr (haddr),
         .tok_i      (tok[i]),
         .tok_o      (tok[i+1])
      );
   end

   aih_ovf #(
      .MAX_BINS       (MAX_BINS),
      .NUM_HISTOGRAMS (NUM_HISTOGRAMS)
   ) u_ovf (
      .clock      (clock),
      .reset      (reset),
      .histo_addr (haddr),
      .tok_i      (tok[MAX_BINS]),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_elapsed     = rsp.elapsed;
   assign rsp_hit_bin     = rsp.hit_bin;
   assign rsp_opened_bin  = rsp.opened_bin;
   assign rsp_filled_bins = filled_ff;
   assign rsp_bin_center  = rsp.bin_center;
   assign rsp_bin_count   = rsp.stats.count;
   assign rsp_bin_min     = rsp.stats.lo;
   assign rsp_bin_max     = rsp.stats.hi;
   assign rsp_bin_in_use  = rsp.bin_in_use;

   // a taken command holds busy until its word leaves the overflow stage
   `AIH_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `AIH_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy && $past(busy))
   `AIH_ASSERT_IMPLY(a_launch_run, clock, reset, tok[0].valid, state_ff == StRun)
   `AIH_ASSERT_IMPLY(a_done_run, clock, reset, chain_done, state_ff == StRun)

endmodule

// ----- src/aih_cell.sv -----
// one ordinary bin cell: per-histogram bin storage, window test and read tap
module aih_cell import aih_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int NUM_HISTOGRAMS = DefNumHistograms,
   localparam int HistoAddrW = (NUM_HISTOGRAMS > 1) ? $clog2(NUM_HISTOGRAMS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic [HistoAddrW-1:0] histo_addr,
   input  token_type             tok_i,
   output token_type             tok_o
);

   function automatic logic in_window(logic [TimeW-1:0] e, logic [TimeW-1:0] c,
                                      logic [BinWidthW-1:0] w);
      logic [TimeW-1:0] up;
      logic [TimeW-1:0] dn;
      logic             r;
      up = e - c;
      dn = c - e;
      if (e >= c) begin
         r = (up[TimeW-1:BinWidthW] == '0) && ({up[BinWidthW-1:0], 1'b0} < {1'b0, w});
      end else begin
         r = (dn[TimeW-1:BinWidthW] == '0) && ({dn[BinWidthW-1:0], 1'b0} <= {1'b0, w});
      end
      return r;
   endfunction

   logic [TimeW-1:0]          center_mem [NUM_HISTOGRAMS];
   stats_type                 stats_mem  [NUM_HISTOGRAMS];
   logic [NUM_HISTOGRAMS-1:0] valid_ff;
   logic [TimeW-1:0]          center_rd_ff;
   stats_type                 stats_rd_ff;
   logic                      valid_rd_ff;
   token_type                 tok_ff;
   token_type                 tok_in;

   logic             in_use;
   logic [TimeW-1:0] center_q;
   stats_type        stats_q;
   stats_type        stats_new;
   logic             active;
   logic             hit;
   logic             do_open;
   logic             do_clear;
   logic             read_sel;
   logic             wr_en;

   always_comb begin
      in_use    = valid_rd_ff;
      center_q  = in_use ? center_rd_ff : '0;
      stats_q   = in_use ? stats_rd_ff : StatsReset;
      active    = tok_i.valid && !tok_i.skip;
      hit       = active && (tok_i.cmd == CmdStop) && in_use &&
                  in_window(tok_i.elapsed, center_q, cfg.bin_width);
      // the first unused bin below the open-bin limit opens when no bin hit
      do_open   = active && (tok_i.cmd == CmdStop) && !in_use && tok_i.prev_open &&
                  !tok_i.counted && (CELL_INDEX < int'(cfg.max_bins_used));
      do_clear  = active && (tok_i.cmd == CmdClear);
      read_sel  = active && (tok_i.cmd == CmdRead) && (int'(tok_i.bin_index) == CELL_INDEX);
      wr_en     = hit || do_open;
      stats_new = do_open ? stats_type'{count: CountW'(1), lo: tok_i.elapsed,
                                        hi: tok_i.elapsed}
                          : tally(stats_q, tok_i.elapsed);

      tok_in           = tok_i;
      tok_in.prev_open = in_use;
      if (hit) begin
         tok_in.counted = 1'b1;
         if (!tok_i.counted) tok_in.first = BinIdxW'(CELL_INDEX);
      end
      if (do_open) begin
         tok_in.opened = 1'b1;
         tok_in.first  = BinIdxW'(CELL_INDEX);
      end
      if (read_sel) begin
         tok_in.center = center_q;
         tok_in.stats  = stats_q;
         tok_in.in_use = in_use;
      end
   end

   always_ff @(posedge clock) begin
      center_rd_ff <= center_mem[histo_addr];
      stats_rd_ff  <= stats_mem[histo_addr];
      if (wr_en) begin
         stats_mem[histo_addr] <= stats_new;
      end
      if (do_open) begin
         center_mem[histo_addr] <= tok_i.elapsed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         valid_rd_ff  <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_rd_ff <= valid_ff[histo_addr];
         tok_ff      <= tok_in;
         if (do_clear) begin
            valid_ff[histo_addr] <= 1'b0;
         end else if (do_open) begin
            valid_ff[histo_addr] <= 1'b1;
         end
      end
   end

   assign tok_o = tok_ff;

endmodule

// ----- src/aih_ovf.sv -----
// overflow bin at the end of the chain and the result register
module aih_ovf import aih_pkg::*; #(
   parameter int MAX_BINS = DefMaxBins,
   parameter int NUM_HISTOGRAMS = DefNumHistograms,
   localparam int HistoAddrW = (NUM_HISTOGRAMS > 1) ? $clog2(NUM_HISTOGRAMS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [HistoAddrW-1:0] histo_addr,
   input  token_type             tok_i,
   output logic                  rsp_valid,
   output rsp_type               rsp
);

   stats_type                 stats_mem [NUM_HISTOGRAMS];
   logic [NUM_HISTOGRAMS-1:0] valid_ff;
   stats_type                 stats_rd_ff;
   logic                      valid_rd_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   stats_type stats_q;
   logic      active;
   logic      do_tally;
   logic      do_clear;
   logic      read_sel;

   always_comb begin
      stats_q  = valid_rd_ff ? stats_rd_ff : StatsReset;
      active   = tok_i.valid && !tok_i.skip;
      do_tally = active && (tok_i.cmd == CmdStop) && !tok_i.counted && !tok_i.opened;
      do_clear = active && (tok_i.cmd == CmdClear);
      read_sel = active && (tok_i.cmd == CmdRead) && (int'(tok_i.bin_index) == MAX_BINS);

      rsp_in = '0;
      if (active && (tok_i.cmd == CmdStop)) begin
         rsp_in.elapsed    = tok_i.elapsed;
         rsp_in.hit_bin    = do_tally ? BinIdxW'(MAX_BINS) : tok_i.first;
         rsp_in.opened_bin = tok_i.opened;
      end
      if (active && (tok_i.cmd == CmdRead)) begin
         if (read_sel) begin
            rsp_in.bin_center = '0;
            rsp_in.stats      = stats_q;
            rsp_in.bin_in_use = 1'b1;
         end else begin
            rsp_in.bin_center = tok_i.center;
            rsp_in.stats      = tok_i.stats;
            rsp_in.bin_in_use = tok_i.in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      stats_rd_ff <= stats_mem[histo_addr];
      if (do_tally) begin
         stats_mem[histo_addr] <= tally(stats_q, tok_i.elapsed);
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         valid_rd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_rd_ff  <= valid_ff[histo_addr];
         rsp_valid_ff <= tok_i.valid;
         if (do_clear) begin
            valid_ff[histo_addr] <= 1'b0;
         end else if (do_tally) begin
            valid_ff[histo_addr] <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
